[hdl/tbuuid_pkg.sv]
package tbuuid_pkg;

	// Field widths fixed by the UUID layout.
	localparam int unsigned SEC_W  = 36;
	localparam int unsigned USEC_W = 20;
	localparam int unsigned ADJ_W  = 4;
	localparam int unsigned SEQ_W  = 14;
	localparam int unsigned TS_W   = 60;
	localparam int unsigned NODE_W = 48;
	localparam int unsigned CFG_W  = 48;

	// Default limit of the sub-microsecond adjustment.
	localparam int unsigned MAX_TICK_ADJUST_DEFAULT = 10;

	// Timestamp arithmetic: 100 ns ticks since the Gregorian reform.
	localparam logic [TS_W-1:0] TICKS_PER_SEC    = 60'd10000000;
	localparam logic [TS_W-1:0] TICKS_PER_USEC   = 60'd10;
	localparam logic [TS_W-1:0] GREGORIAN_OFFSET = 60'h01B21DD213814000;

	// UUID marker bits.
	localparam logic [3:0] UUID_VERSION = 4'h1;
	localparam logic [1:0] UUID_VARIANT = 2'b10;

	// Status codes.
	localparam logic STATUS_ISSUED = 1'b0;
	localparam logic STATUS_RETRY  = 1'b1;

	// Configuration register indexes.
	localparam logic REG_NODE_ADDRESS  = 1'b0;
	localparam logic REG_SEED_SEQUENCE = 1'b1;

	// One time reading.
	typedef struct packed {
		logic [SEC_W-1:0]  now_seconds;
		logic [USEC_W-1:0] now_micros;
	} in_item_t;

	// One UUID or retry answer.
	typedef struct packed {
		logic              status;
		logic [31:0]       time_low_word;
		logic [15:0]       time_mid_word;
		logic [15:0]       time_high_version;
		logic [15:0]       sequence_variant;
		logic [NODE_W-1:0] node_out;
	} out_item_t;

	// Decision of the sequence tracker for the current reading.
	typedef struct packed {
		logic             retry;
		logic [ADJ_W-1:0] tick_adjust;
		logic [SEQ_W-1:0] clock_sequence;
	} track_t;

endpackage

[hdl/tbuuid_track.sv]
module tbuuid_track #(
	parameter int unsigned MAX_TICK_ADJUST = tbuuid_pkg::MAX_TICK_ADJUST_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  tbuuid_pkg::in_item_t                item,
	input  logic [tbuuid_pkg::SEQ_W-1:0]        seed_sequence,
	output tbuuid_pkg::track_t                  decision
);
	import tbuuid_pkg::*;

	logic [SEC_W-1:0]  last_seconds_q, last_seconds_nxt;
	logic [USEC_W-1:0] last_micros_q, last_micros_nxt;
	logic [ADJ_W-1:0]  tick_adjust_q, tick_adjust_nxt;
	logic [SEQ_W-1:0]  clock_sequence_q, clock_sequence_nxt;
	logic              started_q;
	logic              went_back;
	logic              same_time;
	logic              retry;

	// Compare the reading with the last accepted one.
	assign went_back = (item.now_seconds < last_seconds_q) ||
		((item.now_seconds == last_seconds_q) && (item.now_micros < last_micros_q));
	assign same_time = (item.now_seconds == last_seconds_q) &&
		(item.now_micros == last_micros_q);

	// Next state for this reading; a retry leaves the state untouched.
	always_comb begin
		last_seconds_nxt   = last_seconds_q;
		last_micros_nxt    = last_micros_q;
		tick_adjust_nxt    = tick_adjust_q;
		clock_sequence_nxt = clock_sequence_q;
		retry              = 1'b0;
		if (!started_q) begin
			clock_sequence_nxt = seed_sequence;
			tick_adjust_nxt    = '0;
			last_seconds_nxt   = item.now_seconds;
			last_micros_nxt    = item.now_micros;
		end else if (went_back) begin
			clock_sequence_nxt = clock_sequence_q + 1'b1;
			tick_adjust_nxt    = '0;
			last_seconds_nxt   = item.now_seconds;
			last_micros_nxt    = item.now_micros;
		end else if (same_time) begin
			if (tick_adjust_q >= ADJ_W'(MAX_TICK_ADJUST)) begin
				retry = 1'b1;
			end else begin
				tick_adjust_nxt = tick_adjust_q + 1'b1;
			end
		end else begin
			tick_adjust_nxt  = '0;
			last_seconds_nxt = item.now_seconds;
			last_micros_nxt  = item.now_micros;
		end
	end

	assign decision.retry          = retry;
	assign decision.tick_adjust    = tick_adjust_nxt;
	assign decision.clock_sequence = clock_sequence_nxt;

	// State advances once per transaction leaving the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seconds_q   <= '0;
			last_micros_q    <= '0;
			tick_adjust_q    <= '0;
			clock_sequence_q <= '0;
			started_q        <= 1'b0;
		end else if (fire) begin
			last_seconds_q   <= last_seconds_nxt;
			last_micros_q    <= last_micros_nxt;
			tick_adjust_q    <= tick_adjust_nxt;
			clock_sequence_q <= clock_sequence_nxt;
			started_q        <= 1'b1;
		end
	end

endmodule

[hdl/tbuuid_pack.sv]
module tbuuid_pack (
	input  logic                             retry,
	input  logic [tbuuid_pkg::TS_W-1:0]      ticks_from_seconds,
	input  logic [tbuuid_pkg::TS_W-1:0]      ticks_rest,
	input  logic [tbuuid_pkg::SEQ_W-1:0]     clock_sequence,
	input  logic [tbuuid_pkg::NODE_W-1:0]    node_address,
	output tbuuid_pkg::out_item_t            result
);
	import tbuuid_pkg::*;

	logic [TS_W-1:0] timestamp;

	// Final timestamp, wrapping modulo 2^60.
	assign timestamp = ticks_from_seconds + ticks_rest;

	// Lay out the UUID fields, or a bare retry status.
	always_comb begin
		result = '0;
		if (retry) begin
			result.status = STATUS_RETRY;
		end else begin
			result.status            = STATUS_ISSUED;
			result.time_low_word     = timestamp[31:0];
			result.time_mid_word     = timestamp[47:32];
			result.time_high_version = {UUID_VERSION, timestamp[59:48]};
			result.sequence_variant  = {UUID_VARIANT, clock_sequence};
			result.node_out          = node_address;
		end
	end

endmodule

[hdl/time_based_uuid_generator_core.sv]
// Channel   Signals                         Direction  Transaction
// input     in_valid, in_ready, in_data     in         one time reading
// output    out_valid, out_ready, out_data  out        one UUID or retry status
// config    cfg_write, cfg_index, cfg_data  in         one register write
//
// One reading is taken every cycle while the output is not stalled; its result passes
// through the input register, then the arithmetic register, then the result register.
// The tracker compare and state update are done at the input stage.
// Reset clears all valid flags and the tracker state, and loads register defaults.
// A stall on the output holds every full stage; a stage accepts when empty or when the next one frees.
module time_based_uuid_generator_core #(
	parameter int unsigned MAX_TICK_ADJUST = tbuuid_pkg::MAX_TICK_ADJUST_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  tbuuid_pkg::in_item_t              in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output tbuuid_pkg::out_item_t             out_data,
	input  logic                              cfg_write,
	input  logic                              cfg_index,
	input  logic [tbuuid_pkg::CFG_W-1:0]      cfg_data
);
	import tbuuid_pkg::*;

	logic [NODE_W-1:0] node_address_q;
	logic [SEQ_W-1:0]  seed_sequence_q;

	logic              valid_s1;
	in_item_t          item_s1;
	logic              valid_s2;
	logic              retry_s2;
	logic [TS_W-1:0]   sec_ticks_s2;
	logic [TS_W-1:0]   rest_ticks_s2;
	logic [SEQ_W-1:0]  sequence_s2;
	logic              out_valid_q;
	out_item_t         out_data_q;

	logic              out_free;
	logic              s2_free;
	logic              s2_move;
	logic              s1_free;
	logic              s1_move;
	track_t            decision;
	out_item_t         packed_result;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q  <= NODE_W'(1);
			seed_sequence_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_NODE_ADDRESS:  node_address_q  <= cfg_data[NODE_W-1:0];
				REG_SEED_SEQUENCE: seed_sequence_q <= cfg_data[SEQ_W-1:0];
				default:           node_address_q  <= node_address_q;
			endcase
		end
	end

	// Pipeline flow control.
	assign out_free = !out_valid_q || out_ready;
	assign s2_move  = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_move  = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_ready = s1_free;

	// Clock sequence and adjustment tracking.
	tbuuid_track #(
		.MAX_TICK_ADJUST(MAX_TICK_ADJUST)
	) u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (s1_move),
		.item         (item_s1),
		.seed_sequence(seed_sequence_q),
		.decision     (decision)
	);

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (in_valid && s1_free) begin
			item_s1 <= in_data;
		end
	end

	// Tick products and the small terms, registered apart from the final add.
	always_ff @(posedge clk) begin
		if (s1_move) begin
			retry_s2      <= decision.retry;
			sec_ticks_s2  <= TS_W'(item_s1.now_seconds) * TICKS_PER_SEC;
			rest_ticks_s2 <= TS_W'(item_s1.now_micros) * TICKS_PER_USEC
				+ TS_W'(decision.tick_adjust) + GREGORIAN_OFFSET;
			sequence_s2   <= decision.clock_sequence;
		end
	end

	// Field packing.
	tbuuid_pack u_pack (
		.retry             (retry_s2),
		.ticks_from_seconds(sec_ticks_s2),
		.ticks_rest        (rest_ticks_s2),
		.clock_sequence    (sequence_s2),
		.node_address      (node_address_q),
		.result            (packed_result)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (s2_move) begin
			out_data_q <= packed_result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[verif/time_based_uuid_generator_core_tb.sv]
`timescale 1ns / 100ps

module time_based_uuid_generator_core_tb;
	import tbuuid_pkg::*;

	localparam int unsigned ADJ_LIMIT    = MAX_TICK_ADJUST_DEFAULT;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned MAX_REPORTS  = 50;
	localparam longint unsigned TIMEOUT_NS = 4_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_write = 1'b0;
	logic                 cfg_index = REG_NODE_ADDRESS;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Readings waiting to be offered, and UUIDs still owed by the block.
	in_item_t             pending_readings[$];
	out_item_t            expected_uuids[$];
	out_item_t            oldest_uuid;
	logic                 in_taken = 1'b0;
	int unsigned          mismatch_count = 0;

	// Idle and stall rates in percent, and the long receiver hold-off.
	int unsigned          send_idle_pct = 0;
	int unsigned          recv_stall_pct = 0;
	logic                 hold_armed = 1'b0;
	logic                 hold_done = 1'b0;
	int unsigned          hold_count = 0;

	// Predicted tracker state and register contents.
	logic [SEC_W-1:0]     last_sec_seen = '0;
	logic [USEC_W-1:0]    last_usec_seen = '0;
	logic [ADJ_W-1:0]     tick_adj = '0;
	logic [SEQ_W-1:0]     clk_seq = '0;
	logic                 seen_first = 1'b0;
	logic [NODE_W-1:0]    node_cfg = 48'd1;
	logic [SEQ_W-1:0]     seed_cfg = '0;

	// Cursor of the simulated wall clock used by the random readings.
	logic [SEC_W-1:0]     cur_sec = '0;
	logic [USEC_W-1:0]    cur_usec = '0;

	time_based_uuid_generator_core #(
		.MAX_TICK_ADJUST(ADJ_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Prints one line per mismatch (up to a cap) and counts every one.
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want_v);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want_v);
		end
	endtask

	// Updates the tracker for one accepted reading and queues the UUID it should yield.
	task automatic advance_tracker(input in_item_t rd);
		logic [TS_W-1:0] ticks;
		out_item_t       uuid;
		uuid = '0;
		if (!seen_first) begin
			clk_seq = seed_cfg;
			tick_adj = '0;
			last_sec_seen = rd.now_seconds;
			last_usec_seen = rd.now_micros;
			seen_first = 1'b1;
		end else if (rd.now_seconds < last_sec_seen ||
				(rd.now_seconds == last_sec_seen && rd.now_micros < last_usec_seen)) begin
			clk_seq = clk_seq + 1'b1;
			tick_adj = '0;
			last_sec_seen = rd.now_seconds;
			last_usec_seen = rd.now_micros;
		end else if (rd.now_seconds == last_sec_seen && rd.now_micros == last_usec_seen) begin
			// Same microsecond once the adjustment is used up: retry, state untouched.
			if (tick_adj >= ADJ_LIMIT) begin
				uuid.status = STATUS_RETRY;
				expected_uuids.push_back(uuid);
				return;
			end
			tick_adj = tick_adj + 1'b1;
		end else begin
			tick_adj = '0;
			last_sec_seen = rd.now_seconds;
			last_usec_seen = rd.now_micros;
		end
		ticks = TS_W'(rd.now_seconds) * TICKS_PER_SEC + TS_W'(rd.now_micros) * TICKS_PER_USEC
			+ TS_W'(tick_adj) + GREGORIAN_OFFSET;
		uuid.status = STATUS_ISSUED;
		uuid.time_low_word = ticks[31:0];
		uuid.time_mid_word = ticks[47:32];
		uuid.time_high_version = {UUID_VERSION, ticks[59:48]};
		uuid.sequence_variant = {UUID_VARIANT, clk_seq};
		uuid.node_out = node_cfg;
		expected_uuids.push_back(uuid);
	endtask

	// Monitor: checks each delivered UUID and predicts each accepted reading.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_uuids.size() == 0) begin
					report_mismatch("unexpected result", 64'(out_data.status), 64'd0);
				end else begin
					oldest_uuid = expected_uuids.pop_front();
					if (out_data.status !== oldest_uuid.status)
						report_mismatch("status", 64'(out_data.status), 64'(oldest_uuid.status));
					if (out_data.time_low_word !== oldest_uuid.time_low_word)
						report_mismatch("time_low_word", 64'(out_data.time_low_word),
							64'(oldest_uuid.time_low_word));
					if (out_data.time_mid_word !== oldest_uuid.time_mid_word)
						report_mismatch("time_mid_word", 64'(out_data.time_mid_word),
							64'(oldest_uuid.time_mid_word));
					if (out_data.time_high_version !== oldest_uuid.time_high_version)
						report_mismatch("time_high_version", 64'(out_data.time_high_version),
							64'(oldest_uuid.time_high_version));
					if (out_data.sequence_variant !== oldest_uuid.sequence_variant)
						report_mismatch("sequence_variant", 64'(out_data.sequence_variant),
							64'(oldest_uuid.sequence_variant));
					if (out_data.node_out !== oldest_uuid.node_out)
						report_mismatch("node_out", 64'(out_data.node_out),
							64'(oldest_uuid.node_out));
				end
			end
			if (in_valid && in_ready) begin
				advance_tracker(in_data);
			end
		end
		in_taken <= in_valid && in_ready;
	end

	// Driver: offers the next reading once the current transaction is taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data <= pending_readings.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here.
	always @(negedge clk) begin
		if (hold_armed && !hold_done) begin
			out_ready <= 1'b0;
			if (hold_count == HOLD_CYCLES - 1) begin
				hold_done <= 1'b1;
			end
			hold_count <= hold_count + 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic push_reading(input logic [SEC_W-1:0] sec, input logic [USEC_W-1:0] usec);
		in_item_t rd;
		rd.now_seconds = sec;
		rd.now_micros = usec;
		pending_readings.push_back(rd);
	endtask

	// Writes one register while the block is idle and mirrors it in the predictor.
	task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_NODE_ADDRESS) begin
			node_cfg = value[NODE_W-1:0];
		end else begin
			seed_cfg = value[SEQ_W-1:0];
		end
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Waits until every reading is accepted and every UUID has come back.
	task automatic wait_all_issued();
		do @(posedge clk); while (pending_readings.size() != 0 || in_valid);
		do @(negedge clk); while (expected_uuids.size() != 0);
	endtask

	// Mostly plausible clock behavior: repeats, small forward steps, some
	// backward steps and wide jumps, including out-of-range microseconds.
	task automatic queue_random_readings(input int count);
		int n;
		int run;
		int step;
		n = 0;
		while (n < count) begin
			run = 1;
			case ($urandom_range(9))
				0, 1, 2: begin
					run = $urandom_range(1, 14);
				end
				3, 4, 5: begin
					step = $urandom_range(1, 3);
					if (cur_usec >= 20'd999_999 - USEC_W'(step)) begin
						cur_usec = '0;
						cur_sec = cur_sec + 1'b1;
					end else begin
						cur_usec = cur_usec + USEC_W'(step);
					end
				end
				6: begin
					if (cur_usec != 0 && $urandom_range(1)) begin
						cur_usec = cur_usec - 1'b1;
					end else begin
						cur_sec = cur_sec - 1'b1;
					end
				end
				7: begin
					cur_usec = 20'd999_999;
				end
				8: begin
					cur_sec = {4'($urandom_range(0, 15)), 32'($urandom())};
					cur_usec = USEC_W'($urandom());
				end
				default: begin
					cur_sec = {4'($urandom_range(0, 15)), 32'($urandom())};
					cur_usec = USEC_W'($urandom_range(0, 999_999));
				end
			endcase
			repeat (run) push_reading(cur_sec, cur_usec);
			n += run;
		end
	endtask

	// Stimulus and phase control.
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The seed only counts before the first reading; node stays at its default.
		write_register(REG_SEED_SEQUENCE, {34'h2_AAAA_AAAA, 14'h3FFF});

		// Directed: first reading at zero, then the same microsecond until retries.
		push_reading('0, '0);
		repeat (12) push_reading('0, '0);
		push_reading('0, 20'd999_999);
		// Backward step wraps the clock sequence from its maximum.
		push_reading('0, 20'd5);
		push_reading('0, 20'hF_FFFF);
		// Largest reading: the timestamp still stays below 2^60 without wrapping.
		push_reading({SEC_W{1'b1}}, 20'hF_FFFF);
		push_reading({SEC_W{1'b1}}, '0);
		push_reading(36'd1, '0);
		push_reading(36'd1, '0);
		push_reading('0, 20'd999_999);
		push_reading('0, 20'd999_999);
		wait_all_issued();

		// No idling on either side.
		write_register(REG_NODE_ADDRESS, {$urandom(), $urandom()});
		cur_sec = 36'd1_700_000_000;
		cur_usec = '0;
		queue_random_readings(150);
		wait_all_issued();

		// Sender idles often; seed written again, which must not matter now.
		write_register(REG_NODE_ADDRESS, '0);
		write_register(REG_SEED_SEQUENCE, '0);
		send_idle_pct = 53;
		queue_random_readings(150);
		wait_all_issued();

		// Receiver stalls often.
		write_register(REG_NODE_ADDRESS, {CFG_W{1'b1}});
		write_register(REG_SEED_SEQUENCE, 48'h3FFF);
		send_idle_pct = 0;
		recv_stall_pct = 53;
		queue_random_readings(150);
		wait_all_issued();

		// Both sides idle now and then.
		write_register(REG_NODE_ADDRESS, {$urandom(), $urandom()});
		send_idle_pct = 20;
		recv_stall_pct = 20;
		queue_random_readings(150);
		wait_all_issued();

		// Long receiver hold-off while the sender keeps offering: the block must fill.
		write_register(REG_NODE_ADDRESS, 48'h0123_4567_89AB);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_armed = 1'b1;
		queue_random_readings(120);
		wait_all_issued();

		// Final stretch without idling.
		write_register(REG_NODE_ADDRESS, {$urandom(), $urandom()});
		queue_random_readings(80);
		wait_all_issued();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake or lost transaction.
	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[time_based_uuid_generator_core.f]
hdl/tbuuid_pkg.sv
hdl/tbuuid_track.sv
hdl/tbuuid_pack.sv
hdl/time_based_uuid_generator_core.sv
verif/time_based_uuid_generator_core_tb.sv
